// ===== sv/slcd_pkg.sv =====
package slcd_pkg;

	// Frame memory geometry.
	localparam int ROWS    = 10;
	localparam int COLUMNS = 8;
	localparam int COL_W   = $clog2(COLUMNS);

	// Command codes carried in the input tuser.
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_PAIR  = 2'd1;
	localparam logic [1:0] CMD_FILL  = 2'd2;
	localparam logic [1:0] CMD_CLEAR = 2'd3;

	// Base and common line pattern for frames 0 to 7 (bit 0 base, bits 1..4 com0..com3).
	localparam logic [4:0] COM_PATTERN [8] = '{
		5'h05, 5'h1A, 5'h09, 5'h16, 5'h11, 5'h0E, 5'h03, 5'h1C
	};

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic ld_out;
		logic wr_pair;
		logic fill;
		logic clear;
		logic cfg_wr;
	} slcd_cmd_t;

endpackage

// ===== sv/slcd_ctrl.sv =====
module slcd_ctrl import slcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] in_command,
	output logic       out_valid,
	input  logic       out_ready,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	output slcd_cmd_t  cmd
);

	localparam logic ST_EMPTY = 1'b0;
	localparam logic ST_FULL  = 1'b1;

	logic state_q;
	logic state_d;
	logic accept;

	assign in_ready  = (state_q == ST_EMPTY) || out_ready;
	assign out_valid = (state_q == ST_FULL);
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;

	always_comb begin
		cmd         = '0;
		cmd.cfg_wr  = cfg_valid;
		if (accept) begin
			case (in_command)
				CMD_TICK:  cmd.ld_out  = 1'b1;
				CMD_PAIR:  cmd.wr_pair = 1'b1;
				CMD_FILL:  cmd.fill    = 1'b1;
				CMD_CLEAR: cmd.clear   = 1'b1;
				default:   cmd         = cmd;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		if (cmd.ld_out) begin
			state_d = ST_FULL;
		end else if (out_ready) begin
			state_d = ST_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EMPTY;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sv/slcd_dpath.sv =====
module slcd_dpath import slcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  slcd_cmd_t  cmd,
	input  logic [7:0] cfg_data,
	input  logic [7:0] segment_id,
	input  logic [1:0] pair_value,
	input  logic       fill_value,
	input  logic [3:0] frame,
	input  logic [7:0] subframe,
	output logic [4:0] com_pins,
	output logic [1:0] seg_pins,
	output logic [7:0] shift_byte
);

	logic [COLUMNS-1:0] mem_q [ROWS];
	logic [4:0]         com_hold_q;
	logic [1:0]         seg_hold_q;
	logic [7:0]         duty_q;
	logic [4:0]         com_out_q;
	logic [1:0]         seg_out_q;
	logic [7:0]         shift_out_q;

	logic [3:0]         row;
	logic [3:0]         col;
	logic               pair_ok;
	logic [COLUMNS-1:0] fill_word;
	logic               col_ok;
	logic [COL_W-1:0]   rd_col;
	logic [15:0]        col_bits;
	logic               off;
	logic               active;
	logic [4:0]         com_new;
	logic [1:0]         seg_new;
	logic [7:0]         shift_new;

	always_comb begin
		row     = segment_id[7:4];
		col     = segment_id[3:0];
		pair_ok = ({1'b0, row} < 5'(ROWS)) && (({1'b0, col} + 5'd1) < 5'(COLUMNS));
		for (int k = 0; k < COLUMNS; k++) begin
			fill_word[k] = (k % 2 == 1) ? fill_value : ~fill_value;
		end
	end

	// One bit per row at the column selected by the frame; missing rows read zero.
	always_comb begin
		col_ok = {1'b0, frame} < 5'(COLUMNS);
		rd_col = frame[COL_W-1:0];
		for (int r = 0; r < 16; r++) begin
			col_bits[r] = (r < ROWS) ? (mem_q[r % ROWS][rd_col] & col_ok) : 1'b0;
		end
	end

	always_comb begin
		off    = subframe > duty_q;
		active = !frame[3];
		if (active) begin
			com_new   = off ? 5'd0 : COM_PATTERN[frame[2:0]];
			seg_new   = off ? 2'd0 : col_bits[1:0];
			shift_new = off ? 8'd0 : col_bits[9:2];
		end else begin
			com_new   = com_hold_q;
			seg_new   = seg_hold_q;
			shift_new = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++) begin
				mem_q[r] <= '0;
			end
			com_hold_q <= '0;
			seg_hold_q <= '0;
			duty_q     <= '0;
		end else begin
			if (cmd.cfg_wr) begin
				duty_q <= cfg_data;
			end
			if (cmd.clear) begin
				for (int r = 0; r < ROWS; r++) begin
					mem_q[r] <= '0;
				end
			end else if (cmd.fill) begin
				for (int r = 0; r < ROWS; r++) begin
					mem_q[r] <= fill_word;
				end
			end else if (cmd.wr_pair && pair_ok) begin
				for (int r = 0; r < ROWS; r++) begin
					for (int k = 0; k < COLUMNS; k++) begin
						if (4'(r) == row && 4'(k) == col) begin
							mem_q[r][k] <= pair_value[0];
						end else if (4'(r) == row && 4'(k) == col + 4'd1) begin
							mem_q[r][k] <= pair_value[1];
						end
					end
				end
			end
			if (cmd.ld_out) begin
				com_hold_q <= com_new;
				seg_hold_q <= seg_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_out) begin
			com_out_q   <= com_new;
			seg_out_q   <= seg_new;
			shift_out_q <= shift_new;
		end
	end

	assign com_pins   = com_out_q;
	assign seg_pins   = seg_out_q;
	assign shift_byte = shift_out_q;

endmodule

// ===== sv/segment_lcd_mux_driver_unit.sv =====
// Multiplexed segment LCD driver. The block holds a 10 x 8 one-bit frame
// memory in flip-flops, cleared at reset, so no clearing pass is needed. The
// item kind travels in s_axis_tuser: tick, write bit pair, fill alternating,
// or clear all. Every command completes in the cycle it is accepted, so the
// block takes one item per clock. A tick produces one result item, which sits
// in the output register and appears on the master side in the cycle after
// acceptance; the other commands produce no result. The only thing that
// stalls the input is a result held in the output register that the
// downstream side has not taken yet. For frames 0 to 7 the base and common
// pins follow a fixed pattern and the segment pins come from rows 0 and 1;
// for frames above 7 those pins repeat their last driven values and the
// shift byte is zero. Any pin that would be on is forced off when subframe
// exceeds duty_parts, which is written through the cfg port (always ready).
module segment_lcd_mux_driver_unit import slcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// segment_id [7:0], pair_value [9:8], fill_value [10], frame [14:11],
	// subframe [22:15], zero [23]
	input  logic [23:0] s_axis_tdata,
	// command [1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// com_pins [4:0], seg_pins [6:5], shift_byte [14:7], zero [15]
	output logic [15:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	slcd_cmd_t  cmd;
	logic [4:0] com_pins;
	logic [1:0] seg_pins;
	logic [7:0] shift_byte;

	// The controller tracks the output register and decodes accepted items.
	slcd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_command (s_axis_tuser),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cmd        (cmd)
	);

	// The datapath holds the frame memory, hold registers and result register.
	slcd_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg_data   (cfg_data),
		.segment_id (s_axis_tdata[7:0]),
		.pair_value (s_axis_tdata[9:8]),
		.fill_value (s_axis_tdata[10]),
		.frame      (s_axis_tdata[14:11]),
		.subframe   (s_axis_tdata[22:15]),
		.com_pins   (com_pins),
		.seg_pins   (seg_pins),
		.shift_byte (shift_byte)
	);

	assign m_axis_tdata = {1'b0, shift_byte, seg_pins, com_pins};

`ifndef NO_ASSERTIONS
	// A pending result that is not taken must block new items.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
		else $error("input accepted while result is stalled");

	// An accepted tick always yields a result in the next cycle.
	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_TICK) |=> m_axis_tvalid)
		else $error("tick produced no result");

	// Other commands never create a result when the output is empty.
	a_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tuser != CMD_TICK && !m_axis_tvalid)
		|=> !m_axis_tvalid)
		else $error("result without a tick");

	// Dark common lines mean either gating or a held frame, both with no shift data.
	a_dark_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[4:0] == 5'd0) |-> (m_axis_tdata[14:7] == 8'd0))
		else $error("shift data driven with dark common lines");
`endif

endmodule

// ===== bench/segment_lcd_pin_checker.sv =====
`timescale 1ns / 100ps

// Tracks the frame memory, the pin hold registers and duty_parts from the
// items accepted on the input and configuration channels, and compares each
// result item with the oldest pin state still due.
module segment_lcd_pin_checker import slcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,
	input  logic [1:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	output int          mismatches,
	output int          outstanding
);

	// Same order as m_axis_tdata, com_pins in the lowest bits.
	typedef struct packed {
		logic [7:0] shift;
		logic [1:0] seg;
		logic [4:0] com;
	} pin_word_t;

	logic [COLUMNS-1:0] lcd_mem [ROWS];
	logic [4:0]         com_hold;
	logic [1:0]         seg_hold;
	logic [7:0]         duty;
	pin_word_t          pins_due [$];
	int                 fault_count = 0;

	task automatic check_field(input string what, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
			fault_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		logic [7:0] seg_id;
		logic [7:0] sub;
		logic [3:0] frm;
		logic [3:0] row;
		logic [3:0] col;
		logic [1:0] pair;
		logic       fill;
		pin_word_t  due;
		pin_word_t  seen;
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++)
				lcd_mem[r] = '0;
			com_hold = '0;
			seg_hold = '0;
			duty = '0;
			pins_due.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen = m_axis_tdata[14:0];
				if (pins_due.size() == 0) begin
					$display("%0t ns: result item with none expected, expected nothing, got %h",
						$time, seen);
					fault_count++;
				end else begin
					due = pins_due.pop_front();
					check_field("com_pins", 8'(due.com), 8'(seen.com));
					check_field("seg_pins", 8'(due.seg), 8'(seen.seg));
					check_field("shift_byte", due.shift, seen.shift);
				end
			end

			if (cfg_valid && cfg_ready)
				duty = cfg_data;

			if (s_axis_tvalid && s_axis_tready) begin
				{sub, frm, fill, pair, seg_id} = s_axis_tdata[22:0];
				row = seg_id[7:4];
				col = seg_id[3:0];
				case (s_axis_tuser)
					CMD_PAIR: begin
						if (row < ROWS && col < COLUMNS - 1) begin
							lcd_mem[row][col] = pair[0];
							lcd_mem[row][col + 1] = pair[1];
						end
					end
					CMD_FILL: begin
						for (int r = 0; r < ROWS; r++)
							for (int c = 0; c < COLUMNS; c++)
								lcd_mem[r][c] = (c % 2 == 1) ? fill : ~fill;
					end
					CMD_CLEAR: begin
						for (int r = 0; r < ROWS; r++)
							lcd_mem[r] = '0;
					end
					CMD_TICK: begin
						due = '0;
						if (frm <= 4'd7) begin
							due.com = COM_PATTERN[frm[2:0]];
							due.seg = {lcd_mem[1][frm[2:0]], lcd_mem[0][frm[2:0]]};
							for (int r = 0; r < 8; r++)
								if (r + 2 < ROWS)
									due.shift[r] = lcd_mem[r + 2][frm[2:0]];
							if (sub > duty)
								due = '0;
							com_hold = due.com;
							seg_hold = due.seg;
						end
						due.com = com_hold;
						due.seg = seg_hold;
						pins_due.push_back(due);
					end
					default: begin
					end
				endcase
			end
		end
		mismatches <= fault_count;
		outstanding <= pins_due.size();
	end

endmodule

// ===== bench/segment_lcd_mux_driver_unit_tb.sv =====
`timescale 1ns / 100ps

// Top of the bench for the segment LCD driver. It makes the reset, the clock,
// the input items and the duty_parts writes, and toggles the result side's
// ready at random. All checking lives in the checker instance; this module
// only reads its mismatch count and the number of results still due.
module segment_lcd_mux_driver_unit_tb;
	import slcd_pkg::*;

	// Cycles without any accepted item before the run is declared hung. The
	// longest legal quiet stretch is a sender gap plus a receiver stall, plus
	// a few cycles around a configuration write.
	localparam int STALL_LIMIT      = 2000;
	localparam int RANDOM_PER_PHASE = 250;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// segment_id [7:0], pair_value [9:8], fill_value [10], frame [14:11],
	// subframe [22:15], zero [23]
	logic [23:0] s_axis_tdata = '0;
	// command [1:0]
	logic [1:0]  s_axis_tuser = CMD_TICK;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// com_pins [4:0], seg_pins [6:5], shift_byte [14:7], zero [15]
	logic [15:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = '0;

	int          mismatches;
	int          outstanding;
	int          idle_cycles = 0;
	int          calm_left = 0;
	// Set for the last phase: from then on neither side idles.
	logic        settle = 1'b0;
	// Copy of the duty_parts value last written, used to aim subframes at the
	// gating boundary.
	logic [7:0]  duty_now = '0;

	always #1 clk = ~clk;

	segment_lcd_mux_driver_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	segment_lcd_pin_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	// Watchdog: any handshake on any channel restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Result side. Ready is held for bursts of random length, high or low; high
	// bursts may run longer so that stall-free stretches occur too.
	// A burst ends early once the last phase begins.
	initial begin : sink
		int hold;
		logic level;
		forever begin
			@(posedge clk);
			if (settle) begin
				m_axis_tready <= 1'b1;
			end else begin
				level = ($urandom_range(0, 2) != 0);
				hold = level ? $urandom_range(1, 60) : $urandom_range(1, 17);
				m_axis_tready <= level;
				repeat (hold - 1) begin
					if (settle)
						break;
					@(posedge clk);
				end
				if (settle)
					m_axis_tready <= 1'b1;
			end
		end
	end

	// Packs the input fields into tdata, segment_id in the lowest bits.
	function automatic logic [23:0] pack_fields(input logic [7:0] seg_id,
			input logic [1:0] pair, input logic fill, input logic [3:0] frame,
			input logic [7:0] sub);
		return {1'b0, sub, frame, fill, pair, seg_id};
	endfunction

	// Offers one item and returns at the edge where it is taken. Before the
	// item the sender may pause for a burst of random length, except inside
	// calm stretches and in the last phase. Valid stays high from one item to
	// the next when there is no pause.
	task automatic drive_item(input logic [1:0] cmd, input logic [23:0] fields);
		if (!settle) begin
			if (calm_left > 0) begin
				calm_left--;
			end else if ($urandom_range(0, 9) == 0) begin
				calm_left = $urandom_range(10, 60);
			end else if ($urandom_range(0, 3) == 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= fields;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Stops sending and waits until every tick has produced its result item.
	// The count from the checker is registered, hence the first wait. Write
	// commands leave nothing in flight once accepted, so a short pause
	// afterwards covers them.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Writes duty_parts while the block is idle.
	task automatic set_duty(input logic [7:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		duty_now = value;
	endtask

	// One random item. Most are well-formed pair writes into the memory and
	// ticks that read it back; fills and clears are rarer so that the memory
	// keeps a varied pattern. Fields a command does not use stay random.
	task automatic random_item();
		logic [1:0] cmd;
		logic [7:0] seg_id;
		logic [7:0] sub;
		logic [3:0] frame;
		int         pick;
		int         near;
		pick = $urandom_range(0, 99);
		seg_id = 8'($urandom_range(0, 255));
		sub = 8'($urandom_range(0, 255));
		frame = 4'($urandom_range(0, 15));
		if (pick < 45) begin
			cmd = CMD_TICK;
			pick = $urandom_range(0, 19);
			if (pick < 16)
				frame = 4'($urandom_range(0, 7));
			else if (pick < 19)
				frame = 4'($urandom_range(8, 10));
			// Half of the ticks sit right at the gating boundary.
			if ($urandom_range(0, 1) == 1) begin
				near = int'(duty_now) + int'($urandom_range(0, 2)) - 1;
				if (near < 0)
					near = 0;
				if (near > 255)
					near = 255;
				sub = 8'(near);
			end
		end else if (pick < 90) begin
			cmd = CMD_PAIR;
			// Mostly writes that land in the memory; the rest may fall outside.
			if ($urandom_range(0, 7) != 0)
				seg_id = {4'($urandom_range(0, ROWS - 1)), 4'($urandom_range(0, COLUMNS - 2))};
		end else if (pick < 97) begin
			cmd = CMD_FILL;
		end else begin
			cmd = CMD_CLEAR;
		end
		drive_item(cmd, pack_fields(seg_id, 2'($urandom_range(0, 3)),
			1'($urandom_range(0, 1)), frame, sub));
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, duty_parts at its reset value of zero. A tick on the
		// empty memory, then each fill seed read back: one at frames 1 and 0, one at 7.
		drive_item(CMD_TICK, pack_fields(8'h00, 2'd0, 1'b0, 4'd0, 8'd0));
		drive_item(CMD_FILL, pack_fields(8'h00, 2'd0, 1'b1, 4'd0, 8'd0));
		drive_item(CMD_TICK, pack_fields(8'hFF, 2'd3, 1'b1, 4'd1, 8'd0));
		drive_item(CMD_TICK, pack_fields(8'h00, 2'd0, 1'b0, 4'd0, 8'd0));
		drive_item(CMD_FILL, pack_fields(8'hFF, 2'd3, 1'b0, 4'd15, 8'd255));
		drive_item(CMD_TICK, pack_fields(8'h00, 2'd0, 1'b0, 4'd7, 8'd0));
		drive_item(CMD_CLEAR, pack_fields(8'hFF, 2'd3, 1'b1, 4'd15, 8'd255));

		// Pair writes at the corners of the memory, then ones that must be
		// dropped: row above nine, column seven, both out, column far out.
		drive_item(CMD_PAIR, pack_fields(8'h00, 2'd3, 1'b0, 4'd0, 8'd0));
		drive_item(CMD_PAIR, pack_fields(8'h16, 2'd2, 1'b1, 4'd15, 8'd255));
		drive_item(CMD_PAIR, pack_fields(8'h96, 2'd3, 1'b0, 4'd0, 8'd0));
		drive_item(CMD_PAIR, pack_fields(8'hA0, 2'd3, 1'b0, 4'd0, 8'd0));
		drive_item(CMD_PAIR, pack_fields(8'h07, 2'd3, 1'b0, 4'd0, 8'd0));
		drive_item(CMD_PAIR, pack_fields(8'hFF, 2'd3, 1'b0, 4'd0, 8'd0));
		drive_item(CMD_PAIR, pack_fields(8'h5E, 2'd1, 1'b0, 4'd0, 8'd0));

		// Read back, then the held frames eight, ten and fifteen.
		drive_item(CMD_TICK, pack_fields(8'h00, 2'd0, 1'b0, 4'd0, 8'd0));
		drive_item(CMD_TICK, pack_fields(8'h00, 2'd0, 1'b0, 4'd7, 8'd0));
		drive_item(CMD_TICK, pack_fields(8'h00, 2'd0, 1'b0, 4'd6, 8'd0));
		drive_item(CMD_TICK, pack_fields(8'h00, 2'd0, 1'b0, 4'd8, 8'd0));
		drive_item(CMD_TICK, pack_fields(8'h00, 2'd0, 1'b0, 4'd10, 8'd0));
		drive_item(CMD_TICK, pack_fields(8'hFF, 2'd3, 1'b1, 4'd15, 8'd255));

		// Gating: subframe above duty_parts forces lit pins off, and the held
		// frames then repeat the gated values.
		drive_item(CMD_TICK, pack_fields(8'h00, 2'd0, 1'b0, 4'd1, 8'd1));
		drive_item(CMD_TICK, pack_fields(8'h00, 2'd0, 1'b0, 4'd9, 8'd0));
		drive_item(CMD_TICK, pack_fields(8'h00, 2'd0, 1'b0, 4'd0, 8'd255));
		drive_item(CMD_PAIR, pack_fields(8'h00, 2'd0, 1'b0, 4'd0, 8'd0));
		drive_item(CMD_TICK, pack_fields(8'h00, 2'd0, 1'b0, 4'd0, 8'd0));

		// Random phases, each under its own duty_parts setting.
		set_duty(8'd255);
		repeat (RANDOM_PER_PHASE) random_item();
		set_duty(8'($urandom_range(1, 254)));
		repeat (RANDOM_PER_PHASE) random_item();
		set_duty(8'd0);
		repeat (RANDOM_PER_PHASE) random_item();
		set_duty(8'd128);
		repeat (RANDOM_PER_PHASE) random_item();

		// Last phase runs at full rate on both sides.
		settle = 1'b1;
		set_duty(8'($urandom_range(0, 255)));
		repeat (RANDOM_PER_PHASE) random_item();

		drain_results();
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
